// ===== hw/rtl/qpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// qpsd_pkg
// Shared types, character codes and helpers for the query string splitter
// and percent decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qpsd_pkg;

    // Characters with a meaning in a query string
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;

    // Escape tracking, one-hot
    typedef enum logic [2:0] {
        PH_OUT = 3'b001,   // outside an escape
        PH_HI  = 3'b010,   // after '%', waiting for the high digit
        PH_LO  = 3'b100    // after the high digit, waiting for the low digit
    } phase_t;

    // One raw input byte as held in the input register
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } item_t;

    // One result transaction
    typedef struct packed {
        logic       out_valid;
        logic [7:0] decoded_byte;
        logic       in_value_part;
        logic       param_done;
        logic       string_done;
        logic       syntax_error;
    } result_t;

    // Result of a hex digit test
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // Classify one byte as a hex digit of either case
    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        case (c) inside
            [8'h30:8'h39]:
            begin
                h.ok  = 1'b1;
                h.val = c[3:0];
            end
            [8'h41:8'h46], [8'h61:8'h66]:
            begin
                h.ok  = 1'b1;
                h.val = c[3:0] + 4'd9;
            end
            default:
            begin
                h.ok  = 1'b0;
                h.val = 4'd0;
            end
        endcase
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/qpsd_in_stage.sv =====
// ----------------------------------------------------------------------------
// qpsd_in_stage
// Input register: captures one raw byte transaction and holds it until the
// decode stage moves it into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qpsd_in_stage
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [7:0]      s_tdata,   // [7:0] in_byte
    input  wire logic            s_tlast,   // end_of_string
    input  wire logic            advance,
    output logic                 item_valid,
    output qpsd_pkg::item_t      item
);
    import qpsd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Take a new transaction when the register is empty or being drained
    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on acceptance
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.in_byte       <= s_tdata;
            item_reg.end_of_string <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/qpsd_decode.sv =====
// ----------------------------------------------------------------------------
// qpsd_decode
// Parameter splitting and percent decoding of one byte, with the escape,
// key/value and error state that carries from byte to byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qpsd_decode
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire qpsd_pkg::item_t item,
    output qpsd_pkg::result_t    result
);
    import qpsd_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [3:0] nibble_reg;
    logic [3:0] nibble_next;
    logic       after_eq_reg;
    logic       after_eq_next;
    logic       err_hold_reg;
    logic       err_hold_next;

    hex_t       hex;
    logic       eos;
    logic [7:0] c;
    result_t    res;

    assign c   = item.in_byte;
    assign eos = item.end_of_string;
    assign hex = hex_digit(c);

    // Decode one byte and work out the next state
    always_comb
    begin
        phase_next    = phase_reg;
        nibble_next   = nibble_reg;
        after_eq_next = after_eq_reg;
        err_hold_next = err_hold_reg;

        res.out_valid     = 1'b0;
        res.decoded_byte  = 8'd0;
        res.in_value_part = 1'b0;
        res.param_done    = 1'b0;
        res.string_done   = eos;
        res.syntax_error  = 1'b0;

        if (!err_hold_reg)
        begin
            res.in_value_part = after_eq_reg;
            case (phase_reg)
                PH_HI:
                begin
                    if (hex.ok && !eos)
                    begin
                        nibble_next = hex.val;
                        phase_next  = PH_LO;
                    end
                    else
                    begin
                        res.syntax_error = 1'b1;
                    end
                end
                PH_LO:
                begin
                    if (hex.ok)
                    begin
                        res.out_valid    = 1'b1;
                        res.decoded_byte = {nibble_reg, hex.val};
                        res.param_done   = eos;
                        phase_next       = PH_OUT;
                    end
                    else
                    begin
                        res.syntax_error = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_OUT;
                    if (c == CH_PERCENT)
                    begin
                        if (eos)
                        begin
                            res.syntax_error = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_HI;
                        end
                    end
                    else if (c == CH_AMP)
                    begin
                        res.param_done = 1'b1;
                        after_eq_next  = 1'b0;
                    end
                    else if (c == CH_EQUALS && !after_eq_reg)
                    begin
                        after_eq_next     = 1'b1;
                        res.in_value_part = 1'b1;
                        res.param_done    = eos;
                    end
                    else
                    begin
                        res.out_valid    = 1'b1;
                        res.decoded_byte = c;
                        res.param_done   = eos;
                    end
                end
            endcase

            // Drop the item and lock out the rest of the string on a bad escape
            if (res.syntax_error)
            begin
                err_hold_next     = 1'b1;
                phase_next        = PH_OUT;
                res.in_value_part = 1'b0;
                res.param_done    = 1'b0;
                res.out_valid     = 1'b0;
                res.decoded_byte  = 8'd0;
            end
        end

        // Start a fresh string after the last byte
        if (eos)
        begin
            phase_next    = PH_OUT;
            nibble_next   = 4'd0;
            after_eq_next = 1'b0;
            err_hold_next = 1'b0;
        end
    end

    // Advance the state once per decoded transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_OUT;
            nibble_reg   <= 4'd0;
            after_eq_reg <= 1'b0;
            err_hold_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            nibble_reg   <= nibble_next;
            after_eq_reg <= after_eq_next;
            err_hold_reg <= err_hold_next;
        end
    end

    assign result = res;

    // A bad escape before the end of the string locks out what follows
    a_err_locks: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.syntax_error && !eos |=> err_hold_reg)
        else $error("error hold not set after a bad escape");

    // The last byte returns all state to its reset values
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && eos |=> phase_reg == PH_OUT && !after_eq_reg && !err_hold_reg)
        else $error("state not cleared at end of string");

    // While locked out, nothing but string_done comes through
    a_locked_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        err_hold_reg |-> !res.out_valid && !res.param_done && !res.syntax_error)
        else $error("output produced after a syntax error");

    // An escape in progress never sits in the value-free error state
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        err_hold_reg |-> phase_reg == PH_OUT)
        else $error("escape still open while error is held");

endmodule

`default_nettype wire

// ===== hw/rtl/qpsd_out_stage.sv =====
// ----------------------------------------------------------------------------
// qpsd_out_stage
// Result register: holds one decoded transaction for the downstream side and
// decides when the pipeline may advance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qpsd_out_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire qpsd_pkg::result_t result,
    output logic                   advance,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // [7:0] decoded_byte
    output logic [3:0]             m_tuser,   // [0] out_valid, [1] in_value_part,
                                              // [2] param_done, [3] syntax_error
    output logic                   m_tlast    // string_done
);
    import qpsd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Move a decoded item in when the register is empty or being drained
    assign advance = item_valid && (!valid_reg || m_tready);

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.decoded_byte;
    assign m_tuser  = {res_reg.syntax_error, res_reg.param_done,
                       res_reg.in_value_part, res_reg.out_valid};
    assign m_tlast  = res_reg.string_done;

endmodule

`default_nettype wire

// ===== hw/rtl/query_param_splitter_decoder_core.sv =====
// Query string splitter and percent decoder. Raw query string bytes enter on
// the slave stream, one per transaction, with tlast on the final byte; each
// byte yields exactly one result transaction on the master stream. A byte is
// taken every cycle while the master side keeps up, and its result is formed
// by the decode logic between the input register and the result register; a
// stalled master side holds the result and back-pressures the slave side once
// both registers are full. Raw '&' ends a parameter, the first raw '=' moves
// to the value part, and "%hh" escapes are decoded; a malformed escape flags
// syntax_error and the rest of that string is dropped. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
// query_param_splitter_decoder_core
// Top level: input register, byte decoder with its state, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module query_param_splitter_decoder_core
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // end_of_string
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] decoded_byte
    output logic [3:0]      m_tuser,   // [0] out_valid, [1] in_value_part,
                                       // [2] param_done, [3] syntax_error
    output logic            m_tlast    // string_done
);
    import qpsd_pkg::*;

    logic    advance;
    logic    item_valid;
    item_t   item;
    result_t result;

    // Hold the incoming byte
    qpsd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Decode and advance the parser state
    qpsd_decode u_decode
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item),
        .result (result)
    );

    // Hold the result for the master side
    qpsd_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// ===== bench/query_param_splitter_decoder_checker.sv =====
// ----------------------------------------------------------------------------
// query_param_splitter_decoder_checker
// Watches both streams of the query string decoder. It predicts one result
// per accepted input byte and compares each result transaction, field by
// field, with the oldest prediction. It reports the mismatches and the
// number of results still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module query_param_splitter_decoder_checker
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // end_of_string
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,   // [7:0] decoded_byte
    input  wire logic [3:0] m_tuser,   // [0] out_valid, [1] in_value_part,
                                       // [2] param_done, [3] syntax_error
    input  wire logic       m_tlast,   // string_done
    output int              fail_count,
    output int              pending
);
    import qpsd_pkg::*;

    // Predicted decoder state
    phase_t     esc_phase;
    logic [3:0] hi_nib;
    logic       value_part;
    logic       err_hold;

    result_t    expected_decodes[$];
    result_t    want;
    int         errors = 0;

    // Return to the state of a fresh query string
    function void clear_state();
        esc_phase  = PH_OUT;
        hi_nib     = 4'd0;
        value_part = 1'b0;
        err_hold   = 1'b0;
    endfunction

    // {is hex digit, digit value}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    // Advance the predicted state by one raw byte and form its result
    function result_t decode_step(input logic [7:0] c, input logic eos);
        result_t    r;
        logic [4:0] hx;
        logic       bad;
        r   = '0;
        bad = 1'b0;
        hx  = hex_nibble(c);
        if (!err_hold)
        begin
            r.in_value_part = value_part;
            case (esc_phase)
                PH_HI:
                begin
                    if (hx[4] && !eos)
                    begin
                        hi_nib    = hx[3:0];
                        esc_phase = PH_LO;
                    end
                    else
                        bad = 1'b1;
                end
                PH_LO:
                begin
                    if (hx[4])
                    begin
                        r.out_valid    = 1'b1;
                        r.decoded_byte = {hi_nib, hx[3:0]};
                        r.param_done   = eos;
                        esc_phase      = PH_OUT;
                    end
                    else
                        bad = 1'b1;
                end
                default:
                begin
                    esc_phase = PH_OUT;
                    if (c == CH_PERCENT)
                    begin
                        if (eos)
                            bad = 1'b1;
                        else
                            esc_phase = PH_HI;
                    end
                    else if (c == CH_AMP)
                    begin
                        r.param_done = 1'b1;
                        value_part   = 1'b0;
                    end
                    else if (c == CH_EQUALS && !value_part)
                    begin
                        // first raw '=' switches to the value part
                        value_part      = 1'b1;
                        r.in_value_part = 1'b1;
                        r.param_done    = eos;
                    end
                    else
                    begin
                        r.out_valid    = 1'b1;
                        r.decoded_byte = c;
                        r.param_done   = eos;
                    end
                end
            endcase
            // Drop everything on a malformed escape and ignore the rest
            if (bad)
            begin
                err_hold  = 1'b1;
                esc_phase = PH_OUT;
                r         = '0;
            end
        end
        if (eos)
            clear_state();
        r.string_done  = eos;
        r.syntax_error = bad;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Compare result transactions first, then predict from input transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            expected_decodes.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_decodes.size() == 0)
                begin
                    $error("result transaction with no prediction: decoded_byte %0h",
                           m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_decodes.pop_front();
                    check_field("out_valid", 8'(want.out_valid), 8'(m_tuser[0]));
                    check_field("decoded_byte", want.decoded_byte, m_tdata);
                    check_field("in_value_part", 8'(want.in_value_part),
                                8'(m_tuser[1]));
                    check_field("param_done", 8'(want.param_done), 8'(m_tuser[2]));
                    check_field("string_done", 8'(want.string_done), 8'(m_tlast));
                    check_field("syntax_error", 8'(want.syntax_error),
                                8'(m_tuser[3]));
                end
            end
            if (s_tvalid && s_tready)
                expected_decodes.push_back(decode_step(s_tdata, s_tlast));
            fail_count <= errors;
            pending    <= expected_decodes.size();
        end
    end

endmodule

// ===== bench/query_param_splitter_decoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// query_param_splitter_decoder_core_tb
// Drives query strings into the decoder: a directed set of edge cases, then
// random well-formed strings mixed with broken escapes and noise, under
// several sender and receiver idling patterns and one long receiver hold-off.
// The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module query_param_splitter_decoder_core_tb;

    import qpsd_pkg::*;

    localparam int PHASE_ITEMS    = 100;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [3:0] m_tuser;
    logic       m_tlast;

    int         fail_count;
    int         pending;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    bit         hold_off_req   = 1'b0;
    int         idle_cycles    = 0;
    int         ph;

    item_t      query_bytes[$];

    query_param_splitter_decoder_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    query_param_splitter_decoder_checker decode_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Append one raw byte to the pending query stream
    task automatic add_byte(input logic [7:0] b, input logic eos);
        item_t it;
        it.in_byte       = b;
        it.end_of_string = eos;
        query_bytes.push_back(it);
    endtask

    // Hex digit character, case chosen at random
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'd0, n};
        if ($urandom_range(1))
            return 8'h41 + {4'd0, n} - 8'd10;
        return 8'h61 + {4'd0, n} - 8'd10;
    endfunction

    // One key or value character: plain, escaped, or a stray byte
    task automatic add_content_char(input bit allow_eq);
        logic [7:0] b;
        b = 8'd0;
        case ($urandom_range(9))
            0, 1, 2: add_byte(8'(8'h61 + $urandom_range(25)), 1'b0);
            3:       add_byte(8'(8'h30 + $urandom_range(9)), 1'b0);
            4, 5:
            begin
                add_byte(CH_PERCENT, 1'b0);
                add_byte(hex_char(4'($urandom_range(15))), 1'b0);
                add_byte(hex_char(4'($urandom_range(15))), 1'b0);
            end
            6:       add_byte(8'(8'h41 + $urandom_range(25)), 1'b0);
            7:       add_byte(allow_eq ? CH_EQUALS : 8'h6B, 1'b0);
            8:
            begin
                b = 8'($urandom_range(255));
                if (b == CH_PERCENT || b == CH_AMP)
                    b = 8'h2B;
                add_byte(b, 1'b0);
            end
            default: add_byte(8'h2B, 1'b0);
        endcase
    endtask

    // Build one query string: mostly well-formed, some broken, some noise
    task automatic add_random_query();
        int    kind;
        int    nparams;
        int    bad_at;
        int    n;
        item_t last;
        kind    = $urandom_range(9);
        nparams = $urandom_range(1, 4);
        bad_at  = (kind == 1 || kind == 2) ? $urandom_range(nparams - 1) : nparams;
        if (kind == 0)
        begin
            n = $urandom_range(1, 8);
            repeat (n) add_byte(8'($urandom_range(255)), 1'b0);
        end
        else
        begin
            for (int p = 0; p < nparams; p++)
            begin
                if (p > 0)
                    add_byte(CH_AMP, 1'b0);
                n = $urandom_range(4);
                repeat (n) add_content_char(1'b0);
                if ($urandom_range(3) != 0)
                begin
                    add_byte(CH_EQUALS, 1'b0);
                    n = $urandom_range(5);
                    repeat (n) add_content_char(1'b1);
                end
                // Insert a malformed escape inside this parameter
                if (p == bad_at)
                begin
                    add_byte(CH_PERCENT, 1'b0);
                    if ($urandom_range(1))
                        add_byte(hex_char(4'($urandom_range(15))), 1'b0);
                    case ($urandom_range(3))
                        0:       add_byte(CH_AMP, 1'b0);
                        1:       add_byte(8'(8'h67 + $urandom_range(19)), 1'b0);
                        2:       add_byte(8'(8'h47 + $urandom_range(19)), 1'b0);
                        default: add_byte(8'(8'h80 + $urandom_range(127)), 1'b0);
                    endcase
                end
            end
            // Cut an escape short at the end of the string
            if (kind == 3)
            begin
                add_byte(CH_PERCENT, 1'b0);
                if ($urandom_range(1))
                    add_byte(hex_char(4'($urandom_range(15))), 1'b0);
            end
            if (query_bytes.size() == 0)
                add_byte(8'h71, 1'b0);
        end
        // Mark the final byte of the string
        last = query_bytes.pop_back();
        last.end_of_string = 1'b1;
        query_bytes.push_back(last);
    endtask

    // Offer one byte, idling first at the current rate, and wait for acceptance
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it.in_byte;
        s_tlast  <= it.end_of_string;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_queued();
        foreach (query_bytes[i])
            send_item(query_bytes[i]);
        query_bytes.delete();
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
                hold_off_req = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    initial
    begin
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        s_tlast  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes, both '=' kinds, escapes, empty parameter
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(CH_EQUALS, 1'b0);
        add_byte(CH_EQUALS, 1'b0);
        add_byte(CH_PERCENT, 1'b0);
        add_byte(8'h34, 1'b0);
        add_byte(8'h31, 1'b0);
        add_byte(CH_PERCENT, 1'b0);
        add_byte(8'h66, 1'b0);
        add_byte(8'h46, 1'b0);
        add_byte(CH_AMP, 1'b0);
        add_byte(CH_AMP, 1'b0);
        // escape cut by the end on its first digit
        add_byte(CH_PERCENT, 1'b0);
        add_byte(8'h30, 1'b1);
        // lone '%' at the end of a string
        add_byte(CH_PERCENT, 1'b1);
        // bad escape, then ignored bytes up to the end
        add_byte(CH_PERCENT, 1'b0);
        add_byte(8'h47, 1'b0);
        add_byte(CH_AMP, 1'b1);
        // '&' right after the high digit is a bad escape
        add_byte(CH_PERCENT, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(CH_AMP, 1'b0);
        add_byte(8'h79, 1'b1);
        // escape that completes on the final byte
        add_byte(CH_PERCENT, 1'b0);
        add_byte(8'h39, 1'b0);
        add_byte(8'h61, 1'b1);
        // '=' alone as a whole string
        add_byte(CH_EQUALS, 1'b1);
        send_queued();

        // Random phases with different idling patterns
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_off_req   = 1'b1;
                end
                1:
                begin
                    send_idle_pct  = 70;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 70;
                end
                default:
                begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 30;
                end
            endcase
            while (query_bytes.size() < PHASE_ITEMS)
                add_random_query();
            send_queued();
        end
        s_tvalid <= 1'b0;

        // Drain the results still owed, then let stray ones show up
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
